// ===== hw/rtl/bdl_pkg.sv =====
// Shared types and constants for the bounded double-ended list.
// Used by bdl_ctrl, bdl_dp and the top level; depends on nothing.
package bdl_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int ENTRY_BITS  = 32;

	localparam int DATA_BITS = 32;
	localparam int IDX_BITS  = 8;
	localparam int CAP_BITS  = 9;
	localparam int SIZE_BITS = 9;
	localparam int REQ_BITS  = 3;
	localparam int STAT_BITS = 2;

	localparam int PTR_BITS = $clog2(MAX_ENTRIES);
	localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);

	// wide enough to compare count, index and capacity and to add head + offset
	localparam int WMAX_A    = (CNT_BITS > IDX_BITS) ? CNT_BITS : IDX_BITS;
	localparam int WMAX_B    = (WMAX_A > CAP_BITS) ? WMAX_A : CAP_BITS;
	localparam int WIDE_BITS = WMAX_B + 1;

	localparam int CAP_RESET = 256;

	typedef enum logic [REQ_BITS-1:0] {
		REQ_INS_HEAD = 3'd0,
		REQ_INS_TAIL = 3'd1,
		REQ_REM_HEAD = 3'd2,
		REQ_REM_TAIL = 3'd3,
		REQ_RD_IDX   = 3'd4,
		REQ_RD_HEAD  = 3'd5,
		REQ_RD_TAIL  = 3'd6,
		REQ_NONE     = 3'd7
	} req_t;

	typedef enum logic [STAT_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} stat_t;

	typedef enum logic {
		S_IDLE,
		S_RDWAIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_read;
	} dp_cmd_t;

	typedef struct packed {
		logic is_read;
	} dp_stat_t;

endpackage

// ===== hw/rtl/bdl_ram.sv =====
// Generic single-port RAM with registered read data.
// Standalone; no package needed.
module bdl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== hw/rtl/bdl_ctrl.sv =====
// Controller for the bounded double-ended list: accepts words and
// sequences the wait for the registered memory read. Uses bdl_pkg.
module bdl_ctrl import bdl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.accept    = 1'b0;
		cmd.load_read = 1'b0;
		busy          = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (stat.is_read) begin
						state_d = S_RDWAIT;
					end
				end
			end
			S_RDWAIT: begin
				// memory data is valid now; capture it into the result
				busy          = 1'b1;
				cmd.load_read = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/bdl_dp.sv =====
// Datapath of the bounded double-ended list: head pointer, count, capacity
// register, ring memory and result registers. Uses bdl_pkg and bdl_ram.
module bdl_dp import bdl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic [REQ_BITS-1:0]   req_type,
	input  logic [DATA_BITS-1:0]  entry_data,
	input  logic [IDX_BITS-1:0]   read_index,
	input  logic                  capacity_limit_we,
	input  logic [CAP_BITS-1:0]   capacity_limit,
	output logic                  done,
	output logic [DATA_BITS-1:0]  read_data,
	output logic [SIZE_BITS-1:0]  list_size,
	output logic [STAT_BITS-1:0]  status
);

	logic [PTR_BITS-1:0]   head_q, head_d, head_dec, slot;
	logic [CNT_BITS-1:0]   count_q, count_d;
	logic [CAP_BITS-1:0]   cap_q;
	logic [WIDE_BITS-1:0]  count_w, pos_w, sum_w, slot_w;
	logic                  full, empty, ram_we;
	logic [PTR_BITS-1:0]   ram_addr;
	logic [ENTRY_BITS-1:0] ram_rdata;
	stat_t                 st;
	req_t                  req;

	logic                  done_q;
	logic [DATA_BITS-1:0]  res_data_q;
	logic [SIZE_BITS-1:0]  res_size_q;
	stat_t                 res_status_q;

	assign req     = req_t'(req_type);
	assign count_w = WIDE_BITS'(count_q);
	assign full    = (count_w >= WIDE_BITS'(cap_q)) || (count_w >= WIDE_BITS'(MAX_ENTRIES));
	assign empty   = (count_q == '0);
	assign head_dec = (head_q == '0) ? PTR_BITS'(MAX_ENTRIES - 1) : head_q - 1'b1;

	// one ring adder: offset from the head, folded once
	always_comb begin
		unique case (req)
			REQ_INS_TAIL: pos_w = count_w;
			REQ_REM_HEAD: pos_w = WIDE_BITS'(1);
			REQ_RD_IDX:   pos_w = WIDE_BITS'(read_index);
			REQ_RD_TAIL:  pos_w = count_w - 1'b1;
			default:      pos_w = '0;
		endcase
		sum_w  = WIDE_BITS'(head_q) + pos_w;
		slot_w = (sum_w >= WIDE_BITS'(MAX_ENTRIES)) ? sum_w - WIDE_BITS'(MAX_ENTRIES) : sum_w;
		slot   = slot_w[PTR_BITS-1:0];
	end

	always_comb begin
		head_d       = head_q;
		count_d      = count_q;
		st           = ST_OK;
		ram_we       = 1'b0;
		ram_addr     = slot;
		stat.is_read = 1'b0;
		unique case (req)
			REQ_INS_HEAD: begin
				ram_addr = head_dec;
				if (full) begin
					st = ST_FULL;
				end else begin
					head_d  = head_dec;
					ram_we  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			REQ_INS_TAIL: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					ram_we  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			REQ_REM_HEAD: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					head_d  = slot;
					count_d = count_q - 1'b1;
				end
			end
			REQ_REM_TAIL: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			REQ_RD_IDX: begin
				stat.is_read = 1'b1;
				if (WIDE_BITS'(read_index) >= count_w) begin
					st = ST_RANGE;
				end
			end
			REQ_RD_HEAD: begin
				stat.is_read = 1'b1;
				ram_addr     = head_q;
				if (empty) begin
					st = ST_EMPTY;
				end
			end
			REQ_RD_TAIL: begin
				stat.is_read = 1'b1;
				if (empty) begin
					st = ST_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	bdl_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.en    (cmd.accept),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (entry_data[ENTRY_BITS-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			cap_q   <= CAP_BITS'(CAP_RESET);
			done_q  <= 1'b0;
		end else begin
			if (capacity_limit_we) begin
				cap_q <= capacity_limit;
			end
			if (cmd.accept) begin
				head_q  <= head_d;
				count_q <= count_d;
			end
			done_q <= (cmd.accept && !stat.is_read) || cmd.load_read;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_data_q   <= '0;
			res_size_q   <= SIZE_BITS'(WIDE_BITS'(count_d));
			res_status_q <= st;
		end else if (cmd.load_read) begin
			// drop the memory word when the read was refused
			res_data_q <= (res_status_q == ST_OK) ? DATA_BITS'(ram_rdata) : '0;
		end
	end

	assign done      = done_q;
	assign read_data = res_data_q;
	assign list_size = res_size_q;
	assign status    = res_status_q;

endmodule

// ===== hw/rtl/bounded_double_ended_list.sv =====
// Top level of the bounded double-ended list.
// Joins bdl_ctrl and bdl_dp; uses bdl_pkg.

// A word is taken when start is high and busy is low. Inserts, removals and
// the unused request code give their result with done in the next cycle while
// busy stays low, so a word can follow every cycle. Reads (indexed, head,
// tail) pass through the S_RDWAIT state, busy being high there, since the ring
// memory's registered read port delivers the entry in the cycle after the
// address. Each result is shown for exactly one cycle with done high and
// must be taken then; the receiver cannot stall. capacity_limit may be written
// whenever no request is in flight and takes effect on the next request.
module bounded_double_ended_list import bdl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [REQ_BITS-1:0]  req_type,
	input  logic [DATA_BITS-1:0] entry_data,
	input  logic [IDX_BITS-1:0]  read_index,
	input  logic                 capacity_limit_we,
	input  logic [CAP_BITS-1:0]  capacity_limit,
	output logic                 done,
	output logic [DATA_BITS-1:0] read_data,
	output logic [SIZE_BITS-1:0] list_size,
	output logic [STAT_BITS-1:0] status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bdl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	bdl_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.req_type          (req_type),
		.entry_data        (entry_data),
		.read_index        (read_index),
		.capacity_limit_we (capacity_limit_we),
		.capacity_limit    (capacity_limit),
		.done              (done),
		.read_data         (read_data),
		.list_size         (list_size),
		.status            (status)
	);

endmodule
